### src/mdte_pkg.sv
// Shared types, constants and entity tables for the marker-delimited text extractor.
`timescale 1ns / 1ps

package mdte_pkg;

    localparam int TEXT_DEPTH = 64;
    localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
    localparam int CNT_W      = $clog2(TEXT_DEPTH + 1);
    localparam int BEGIN_MAX  = 24;
    localparam int END_MAX    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int ENT_NUM    = 6;
    localparam int ENT_MAXLEN = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LEN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LIMIT = 3'd6;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [2:0] OUT_END_MARKER = 3'd0;
    localparam logic [2:0] OUT_BAIL       = 3'd1;
    localparam logic [2:0] OUT_LIMIT      = 3'd2;
    localparam logic [2:0] OUT_STREAM_END = 3'd3;
    localparam logic [2:0] OUT_NOT_FOUND  = 3'd4;

    localparam logic [7:0] CHAR_LT = 8'h3C;

    // Pattern bytes, first byte at index 0; unused tail bytes are zero.
    localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAXLEN] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B},  // &amp;
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // amp;
        '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},  // apos;
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // lt;
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // gt;
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}   // quot;
    };
    localparam logic [2:0] ENT_LEN  [ENT_NUM] = '{3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd5};
    localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{8'h00, 8'h26, 8'h27, 8'h3C, 8'h3E, 8'h22};
    localparam logic       ENT_DEL  [ENT_NUM] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    // Tail window: element 0 is the newest stored byte.
    typedef logic [ENT_MAXLEN-1:0][7:0] t_win;

    typedef struct packed {
        logic       hit;
        logic       del;
        logic [2:0] len;
        logic [7:0] chr;
    } t_ent_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_READ,
        ST_MATCH,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

endpackage

### src/mdte_text_ram.sv
// Text store: one write port, one registered read port.
`timescale 1ns / 1ps

module mdte_text_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [mdte_pkg::TEXT_AW-1:0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic [mdte_pkg::TEXT_AW-1:0] i_raddr,
    output logic [7:0]                 o_rdata
);

    logic [7:0] r_mem [mdte_pkg::TEXT_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/mdte_entity_match.sv
// Entity compare unit: tests the stored tail against the six patterns in priority order.
`timescale 1ns / 1ps

module mdte_entity_match (
    input  mdte_pkg::t_win                 i_win,
    input  logic [mdte_pkg::CNT_W-1:0]     i_count,
    output mdte_pkg::t_ent_res             o_res
);

    always_comb begin
        logic ok;
        o_res = '0;
        // Walk from lowest priority up so the first pattern in the list wins.
        for (int p = mdte_pkg::ENT_NUM - 1; p >= 0; p--) begin
            ok = (i_count >= mdte_pkg::CNT_W'(mdte_pkg::ENT_LEN[p]));
            for (int j = 0; j < mdte_pkg::ENT_MAXLEN; j++) begin
                if (j < int'(mdte_pkg::ENT_LEN[p])) begin
                    if (i_win[int'(mdte_pkg::ENT_LEN[p]) - 1 - j] != mdte_pkg::ENT_TEXT[p][j]) begin
                        ok = 1'b0;
                    end
                end
            end
            if (ok) begin
                o_res.hit = 1'b1;
                o_res.del = mdte_pkg::ENT_DEL[p];
                o_res.len = mdte_pkg::ENT_LEN[p];
                o_res.chr = mdte_pkg::ENT_CHAR[p];
            end
        end
    end

endmodule

### src/marker_delimited_text_extractor.sv
// Top level of the marker-delimited text extractor: sequencer, registers and output stage.
`timescale 1ns / 1ps

// The block scans a byte stream for a configurable begin marker (up to 24 bytes, naive
// match that restarts from zero on any mismatch), then collects text until the end
// marker (up to 8 bytes), a '<' byte, the character limit (up to 64) or a stream-end
// transaction. Bytes that partially match the end marker are held and written to the
// text store, followed by the new byte, once the match breaks. After every collected
// byte the last five stored characters are read back and checked for the XML entities
// &amp; (deleted), amp; apos; lt; gt; quot; (replaced by their character). When a run
// ends the text is sent out one character per transaction, with last on the final one
// and the run outcome on all of them; an empty run yields one transaction with
// has_byte low. A byte while searching, or one that completes or aborts a run, is
// taken in the idle state alone; a byte that extends an end-marker match goes on to the
// tail read and entity check; any other byte first flushes the held end-marker bytes
// and itself to the text store. The text store takes the flush writes one per cycle on its write
// port and returns the five tail bytes one per cycle on its registered read port.
// Emission reads each character on that same read port, and the input is not ready until
// the last character reaches the output register. The output register lets a new
// transaction be accepted while the final character still waits. Configuration writes
// take effect at once and are accepted at any time.

module marker_delimited_text_extractor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [mdte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mdte_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [7:0]                        i_data_byte,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_text_byte,
    output logic                              o_has_byte,
    output logic                              o_last,
    output logic [2:0]                        o_outcome
);

    localparam int CW = mdte_pkg::CNT_W;
    localparam int AW = mdte_pkg::TEXT_AW;

    // Configuration registers
    logic [63:0] r_begin_low, r_begin_mid, r_begin_high, r_end_marker;
    logic [4:0]  r_begin_len;
    logic [3:0]  r_end_len;
    logic [6:0]  r_text_limit;

    // Control state
    mdte_pkg::t_state r_state, n_state;
    logic             r_phase, n_phase;
    logic [4:0]       r_bm, n_bm;
    logic [3:0]       r_em, n_em;
    logic [CW-1:0]    r_count, n_count;
    logic [5:0]       r_k, n_k;
    logic [2:0]       r_run_out, n_run_out;
    logic             r_out_valid, n_out_valid;

    // Payload registers
    logic [7:0]       r_byte, n_byte;
    mdte_pkg::t_win   r_win, n_win;
    logic [7:0]       r_pend [mdte_pkg::END_MAX];
    logic [7:0]       r_text_byte, n_text_byte;
    logic             r_has_byte, n_has_byte;
    logic             r_last, n_last;
    logic [2:0]       r_outcome, n_outcome;

    // Datapath controls
    logic             pend_we;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;
    mdte_pkg::t_ent_res ent;

    // Clamped lengths
    logic [4:0]    blen;
    logic [3:0]    elen;
    logic [CW-1:0] limit;

    logic [7:0]    begin_byte, end_byte, flush_byte;
    logic [191:0]  begin_all;
    logic [CW-1:0] tail_addr, ent_base;
    logic          emit_last;

    assign blen  = (r_begin_len == 5'd0) ? 5'd1 :
                   (r_begin_len > 5'(mdte_pkg::BEGIN_MAX)) ? 5'(mdte_pkg::BEGIN_MAX) : r_begin_len;
    assign elen  = (r_end_len == 4'd0) ? 4'd1 :
                   (r_end_len > 4'(mdte_pkg::END_MAX)) ? 4'(mdte_pkg::END_MAX) : r_end_len;
    assign limit = (r_text_limit == 7'd0) ? CW'(1) :
                   (CW'(r_text_limit) > CW'(mdte_pkg::TEXT_DEPTH)) ? CW'(mdte_pkg::TEXT_DEPTH)
                                                                 : CW'(r_text_limit);

    assign begin_all  = {r_begin_high, r_begin_mid, r_begin_low};
    assign begin_byte = begin_all[{r_bm, 3'b000} +: 8];
    assign end_byte   = r_end_marker[{r_em[2:0], 3'b000} +: 8];
    assign flush_byte = ({2'b00, r_em} > r_k) ? r_pend[r_k[2:0]] : r_byte;
    assign tail_addr  = r_count + CW'(r_k) - CW'(mdte_pkg::ENT_MAXLEN);
    assign ent_base   = r_count - CW'(ent.len);
    assign emit_last  = (r_count == CW'(0)) || (CW'(r_k) + CW'(1) == r_count);

    assign o_in_ready  = (r_state == mdte_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_text_byte = r_text_byte;
    assign o_has_byte  = r_has_byte;
    assign o_last      = r_last;
    assign o_outcome   = r_outcome;

    mdte_text_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mdte_entity_match u_ent (
        .i_win   (r_win),
        .i_count (r_count),
        .o_res   (ent)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_low  <= '0;
            r_begin_mid  <= '0;
            r_begin_high <= '0;
            r_begin_len  <= 5'd1;
            r_end_marker <= '0;
            r_end_len    <= 4'd1;
            r_text_limit <= 7'd64;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mdte_pkg::CFG_BEGIN_LOW:  r_begin_low  <= i_cfg_wdata;
                mdte_pkg::CFG_BEGIN_MID:  r_begin_mid  <= i_cfg_wdata;
                mdte_pkg::CFG_BEGIN_HIGH: r_begin_high <= i_cfg_wdata;
                mdte_pkg::CFG_BEGIN_LEN:  r_begin_len  <= i_cfg_wdata[4:0];
                mdte_pkg::CFG_END_MARKER: r_end_marker <= i_cfg_wdata;
                mdte_pkg::CFG_END_LEN:    r_end_len    <= i_cfg_wdata[3:0];
                mdte_pkg::CFG_TEXT_LIMIT: r_text_limit <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Held end-marker bytes
    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pend[r_em[2:0]] <= i_data_byte;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mdte_pkg::ST_IDLE;
            r_phase     <= 1'b0;
            r_bm        <= '0;
            r_em        <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_run_out   <= mdte_pkg::OUT_NOT_FOUND;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bm        <= n_bm;
            r_em        <= n_em;
            r_count     <= n_count;
            r_k         <= n_k;
            r_run_out   <= n_run_out;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_win       <= n_win;
        r_text_byte <= n_text_byte;
        r_has_byte  <= n_has_byte;
        r_last      <= n_last;
        r_outcome   <= n_outcome;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_bm        = r_bm;
        n_em        = r_em;
        n_count     = r_count;
        n_k         = r_k;
        n_run_out   = r_run_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_byte      = r_byte;
        n_win       = r_win;
        n_text_byte = r_text_byte;
        n_has_byte  = r_has_byte;
        n_last      = r_last;
        n_outcome   = r_outcome;
        pend_we     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = flush_byte;
        ram_raddr   = r_k;

        case (r_state)
            mdte_pkg::ST_IDLE: begin
                n_k = '0;
                if (i_in_valid) begin
                    n_byte = i_data_byte;
                    if (!r_phase) begin
                        if (i_command == mdte_pkg::CMD_END) begin
                            n_count   = '0;
                            n_run_out = mdte_pkg::OUT_NOT_FOUND;
                            n_state   = mdte_pkg::ST_EMIT_RD;
                        end else if (i_data_byte == begin_byte) begin
                            // advance the begin match; enter the text phase when complete
                            if ({1'b0, r_bm} + 6'd1 >= {1'b0, blen}) begin
                                n_phase = 1'b1;
                                n_bm    = '0;
                                n_em    = '0;
                                n_count = '0;
                            end else begin
                                n_bm = r_bm + 5'd1;
                            end
                        end else begin
                            n_bm = '0;
                        end
                    end else if (i_command == mdte_pkg::CMD_END) begin
                        n_run_out = mdte_pkg::OUT_STREAM_END;
                        n_state   = mdte_pkg::ST_EMIT_RD;
                    end else if (r_em < 4'(mdte_pkg::END_MAX) && i_data_byte == end_byte) begin
                        // hold the byte; finish on a full end marker
                        pend_we = 1'b1;
                        n_em    = r_em + 4'd1;
                        if (r_em + 4'd1 >= elen) begin
                            n_run_out = mdte_pkg::OUT_END_MARKER;
                            n_state   = mdte_pkg::ST_EMIT_RD;
                        end else begin
                            n_state = mdte_pkg::ST_READ;
                        end
                    end else if (i_data_byte == mdte_pkg::CHAR_LT) begin
                        n_run_out = mdte_pkg::OUT_BAIL;
                        n_state   = mdte_pkg::ST_EMIT_RD;
                    end else begin
                        n_state = mdte_pkg::ST_FLUSH;
                    end
                end
            end

            mdte_pkg::ST_FLUSH: begin
                // release held bytes, then the new byte; drop what exceeds the limit
                if (r_count < limit) begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
                if (CW'(r_k) == CW'(r_em)) begin
                    n_em    = '0;
                    n_k     = '0;
                    n_state = mdte_pkg::ST_READ;
                end else begin
                    n_k = r_k + 6'd1;
                end
            end

            mdte_pkg::ST_READ: begin
                // read the last five stored bytes into the tail window
                ram_raddr = tail_addr[AW-1:0];
                if (r_k != 6'd0) begin
                    n_win = {r_win[mdte_pkg::ENT_MAXLEN-2:0], ram_rdata};
                end
                if (r_k == 6'(mdte_pkg::ENT_MAXLEN)) begin
                    n_k     = '0;
                    n_state = mdte_pkg::ST_MATCH;
                end else begin
                    n_k = r_k + 6'd1;
                end
            end

            mdte_pkg::ST_MATCH: begin
                n_k = '0;
                if (ent.hit) begin
                    if (ent.del) begin
                        n_count = ent_base;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ent_base[AW-1:0];
                        ram_wdata = ent.chr;
                        n_count   = ent_base + CW'(1);
                    end
                end
                if (n_count >= limit) begin
                    n_run_out = mdte_pkg::OUT_LIMIT;
                    n_state   = mdte_pkg::ST_EMIT_RD;
                end else begin
                    n_state = mdte_pkg::ST_IDLE;
                end
            end

            mdte_pkg::ST_EMIT_RD: begin
                n_state = mdte_pkg::ST_EMIT_OUT;
            end

            mdte_pkg::ST_EMIT_OUT: begin
                // hold until the output register is free, then load one character
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_has_byte  = (r_count != CW'(0));
                    n_text_byte = (r_count != CW'(0)) ? ram_rdata : 8'h00;
                    n_last      = emit_last;
                    n_outcome   = r_run_out;
                    if (emit_last) begin
                        n_phase = 1'b0;
                        n_bm    = '0;
                        n_em    = '0;
                        n_count = '0;
                        n_k     = '0;
                        n_state = mdte_pkg::ST_IDLE;
                    end else begin
                        n_k     = r_k + 6'd1;
                        n_state = mdte_pkg::ST_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = mdte_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
